FILE: hdl/fcks_pkg.sv
package fcks_pkg;

    localparam int FUNC_BITS  = 2;
    localparam int KEY_W      = 32;
    localparam int COUNT_BITS = 5;

    localparam logic [FUNC_BITS-1:0] FUNC_INSERT   = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_ERASE    = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_CONTAINS = 2'd2;

    typedef struct packed {
        logic [FUNC_BITS-1:0] func;
        logic [KEY_W-1:0]     key;
    } t_req;

    typedef struct packed {
        logic                  success;
        logic [COUNT_BITS-1:0] item_count;
        logic                  set_empty;
        logic                  set_full;
    } t_rsp;

endpackage

FILE: hdl/fixed_capacity_key_set_top.sv
// fixed capacity key set: up to CAPACITY keys held in slots with valid bits.
// request channel: drive i_req with an operation (insert, erase, contains)
// and a key, and raise start. the request is taken at a rising edge where
// start is high and busy is low. busy stays high while the request runs.
// result channel: o_done is high for exactly one cycle with o_rsp holding
// success, the item count after the operation, and the empty and full flags.
// the receiver cannot stall: the result must be captured in that cycle.
// timing: the key store has one write port and one registered read port, and
// one comparator walks all CAPACITY slots for every request. o_done rises at
// the same edge at which busy drops, and a new request is not accepted until
// busy is low, so requests do not overlap.
// only the low KEY_BITS bits of the key are stored and compared.
// reset (i_rst_n low, synchronous) empties the set and returns to idle; key
// contents are not cleared, since a slot's key is only compared while it is valid.
module fixed_capacity_key_set_top #(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  fcks_pkg::t_req i_req,
    output logic           o_done,
    output fcks_pkg::t_rsp o_rsp
);
    import fcks_pkg::*;

    localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int KB32 = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_ACT
    } t_state;

    t_state                r_state, n_state;
    logic [FUNC_BITS-1:0]  r_func, n_func;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [IW-1:0]         r_idx, n_idx;
    logic                  r_found, n_found;
    logic [IW-1:0]         r_found_idx, n_found_idx;
    logic                  r_free, n_free;
    logic [IW-1:0]         r_free_idx, n_free_idx;
    logic [CAPACITY-1:0]   r_valid, n_valid;
    logic [CW-1:0]         r_count, n_count;
    logic                  r_done, n_done;
    t_rsp                  r_rsp, n_rsp;

    // read pipeline beside the key memory
    logic                  r_rd_vld;
    logic [IW-1:0]         r_rd_idx;
    logic                  r_rd_vbit;
    logic [KEY_BITS-1:0]   r_rd_key;

    logic [KEY_BITS-1:0]   r_slot_keys [CAPACITY];
    logic                  mem_we;
    logic                  ok;
    logic [KEY_BITS-1:0]   key_in;

    assign key_in = KEY_BITS'(i_req.key[KB32-1:0]);

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_key       = r_key;
        n_idx       = r_idx;
        n_found     = r_found;
        n_found_idx = r_found_idx;
        n_free      = r_free;
        n_free_idx  = r_free_idx;
        n_valid     = r_valid;
        n_count     = r_count;
        n_done      = 1'b0;
        n_rsp       = r_rsp;
        mem_we      = 1'b0;
        ok          = 1'b0;

        // shared comparator: one slot per cycle, keep the lowest hits
        if (r_rd_vld) begin
            if (r_rd_vbit && (r_rd_key == r_key) && !r_found) begin
                n_found     = 1'b1;
                n_found_idx = r_rd_idx;
            end
            if (!r_rd_vbit && !r_free) begin
                n_free     = 1'b1;
                n_free_idx = r_rd_idx;
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_SCAN;
                    n_func  = i_req.func;
                    n_key   = key_in;
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_free  = 1'b0;
                end
            end
            ST_SCAN: begin
                n_idx = r_idx + 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_ACT;
            end
            ST_ACT: begin
                case (r_func)
                    FUNC_INSERT: begin
                        if (!r_found && r_free) begin
                            mem_we              = 1'b1;
                            n_valid[r_free_idx] = 1'b1;
                            n_count             = r_count + 1'b1;
                            ok                  = 1'b1;
                        end
                    end
                    FUNC_ERASE: begin
                        if (r_found) begin
                            n_valid[r_found_idx] = 1'b0;
                            n_count              = r_count - 1'b1;
                            ok                   = 1'b1;
                        end
                    end
                    FUNC_CONTAINS: begin
                        ok = r_found;
                    end
                    default: begin
                        ok = 1'b0;
                    end
                endcase
                n_rsp.success    = ok;
                n_rsp.item_count = COUNT_BITS'(n_count);
                n_rsp.set_empty  = (n_count == '0);
                n_rsp.set_full   = (n_count == FULL_CNT);
                n_done           = 1'b1;
                n_state          = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_valid  <= '0;
            r_count  <= '0;
            r_done   <= 1'b0;
            r_found  <= 1'b0;
            r_free   <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_count  <= n_count;
            r_done   <= n_done;
            r_found  <= n_found;
            r_free   <= n_free;
            r_rd_vld <= (r_state == ST_SCAN);
        end
        r_func      <= n_func;
        r_key       <= n_key;
        r_idx       <= n_idx;
        r_found_idx <= n_found_idx;
        r_free_idx  <= n_free_idx;
        r_rsp       <= n_rsp;
        r_rd_idx    <= r_idx;
        r_rd_vbit   <= r_valid[r_idx];
    end

    // key store: one write port for insert, one registered read port used during scan
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_slot_keys[r_free_idx] <= r_key;
        end
        r_rd_key <= r_slot_keys[r_idx];
    end

    assign busy   = (r_state != ST_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule
